// ===== src/tpbc_pkg.sv =====
// Shared types and constants of the three-plane boundary coincidence block.
package tpbc_pkg;

    localparam int NUM_PLANES = 3;
    localparam int WIRE_W     = 12;
    localparam int CHG_W      = 16;
    localparam int COL_W      = 10;
    localparam int IDX_W      = 10;
    localparam int BND_W      = 2;
    localparam int FUNC_W     = 2;
    localparam int MASK_W     = 17;
    localparam int BASE_W     = 11;
    localparam int RAD_W      = 5;   // effective radius, up to 15
    localparam int NIDX_W     = 5;   // scan position, 0..16
    localparam int DS_W       = 5;
    localparam int ROWC_W     = 11;
    localparam int WIDTH_W    = 13;  // row width after clamp, up to 2047
    localparam int POS_W      = 14;  // signed column during the scan
    localparam int DIV_STEPS  = WIRE_W;

    // Stream payload layout
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;

    localparam int S_BND_LSB  = 0;
    localparam int S_IDX_LSB  = 2;
    localparam int S_WIRE_LSB = 12;   // wire_u, wire_v, wire_y
    localparam int S_COL_LSB  = 48;
    localparam int S_CHG_LSB  = 58;   // charge_u, charge_v, charge_y

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THR_U   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_V   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_U   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_V   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROWCOLS = 3'd7;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_ENTRY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_PIXEL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL       = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TRD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

endpackage

// ===== src/three_plane_boundary_coincidence.sv =====
// Three-plane boundary coincidence: wire-triple tables, one image row, match evaluation.
//
// Input stream (s_*): s_tuser carries the function. Load-entry and load-pixel
// transfers write the match table or the row store and give no result; they
// leave the block idle, so loads stream back to back. An evaluate transfer gives
// exactly one result on the m_* stream, m_tuser being the match flag.
// Evaluation: one table read, a 12-step restoring division of all three wires
// by the downsample factor in lockstep, then a scan of min(2*MAX_RADIUS,16)+1
// neighbour columns, one read of each plane's row RAM per cycle, and a drain
// step. An in-range evaluate keeps s_tready low until its result is in the
// output register; an out-of-range entry index skips the table read, the
// division and the scan and goes straight to the last step.
// Results sit in an output register; if the receiver stalls, a finished
// evaluation waits in its last step until the register frees up.
// Config writes (cfg_*) are always accepted and must only happen while idle.
// Reset (aresetn low, synchronous) restores the state and config registers
// to their defaults and empties the output; table and row contents are not cleared.
module three_plane_boundary_coincidence #(
    parameter int COLUMNS              = 1024,
    parameter int ENTRIES_PER_BOUNDARY = 1024,
    parameter int MAX_RADIUS           = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // boundary, entry_index, wire_u, wire_v, wire_y, column,
    // charge_u, charge_v, charge_y, zero fill
    input  logic [tpbc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [tpbc_pkg::S_TUSER_W-1:0]    s_tuser,   // func
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_boundary, out_index, base_col_u, base_col_v, base_col_y,
    // mask_u, mask_v, mask_y
    output logic [tpbc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [tpbc_pkg::M_TUSER_W-1:0]    m_tuser,   // matched
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tpbc_pkg::*;

    localparam int AW        = $clog2(COLUMNS);
    localparam int TAW       = $clog2(4 * ENTRIES_PER_BOUNDARY);
    localparam int SCAN_LAST = (2 * MAX_RADIUS > MASK_W - 1) ? MASK_W - 1 : 2 * MAX_RADIUS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WIDTH_W-1:0] COLUMNS_W = WIDTH_W'(COLUMNS);
    localparam logic [WIDTH_W-1:0] ENTRIES_W = WIDTH_W'(ENTRIES_PER_BOUNDARY);
    localparam logic [POS_W-1:0]   EPB_P     = POS_W'(ENTRIES_PER_BOUNDARY);

    // configuration
    logic signed [CHG_W-1:0] thr_reg  [NUM_PLANES];
    logic signed [CHG_W-1:0] thr_next [NUM_PLANES];
    logic [3:0]              rad_reg  [NUM_PLANES];
    logic [3:0]              rad_next [NUM_PLANES];
    logic [DS_W-1:0]         ds_reg, ds_next;
    logic [ROWC_W-1:0]       rowc_reg, rowc_next;

    // control and datapath
    state_t                  state_reg, state_next;
    logic [BND_W-1:0]        bnd_reg, bnd_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [TAW-1:0]          slot_reg, slot_next;
    logic                    inrange_reg, inrange_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NIDX_W-1:0]       n_reg, n_next;
    logic [NIDX_W-1:0]       pn_reg, pn_next;
    logic                    pv_reg, pv_next;
    logic [NUM_PLANES-1:0]   pok_reg, pok_next;
    logic [NUM_PLANES-1:0][WIRE_W-1:0] q_reg, q_next;
    logic [NUM_PLANES-1:0][DS_W-1:0]   rem_reg, rem_next;
    logic [NUM_PLANES-1:0][MASK_W-1:0] mask_reg, mask_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // combinational helpers
    logic                    s_xfer;
    logic [FUNC_W-1:0]       in_func;
    logic [BND_W-1:0]        in_bnd;
    logic [IDX_W-1:0]        in_idx;
    logic [COL_W-1:0]        in_col;
    logic                    in_idx_ok;
    logic                    in_col_ok;
    logic [POS_W-1:0]        in_slot;
    logic [WIDTH_W-1:0]      in_col_w;
    logic [DS_W-1:0]         ds_eff;
    logic [WIDTH_W-1:0]      width_eff;
    logic [RAD_W-1:0]        r_eff  [NUM_PLANES];
    logic [POS_W-1:0]        cmr    [NUM_PLANES];
    logic [POS_W-1:0]        pos    [NUM_PLANES];
    logic [NUM_PLANES-1:0]   pos_ok;
    logic [DS_W:0]           shifted [NUM_PLANES];
    logic [DS_W:0]           diff    [NUM_PLANES];
    logic                    out_free;
    logic                    matched;

    // memories
    logic                              tbl_we;
    logic [NUM_PLANES*WIRE_W-1:0]      tbl_rdata;
    logic                              row_we;
    logic [AW-1:0]                     row_raddr [NUM_PLANES];
    logic [CHG_W-1:0]                  row_rdata [NUM_PLANES];

    assign s_xfer    = s_tvalid && s_tready;
    assign in_func   = s_tuser;
    assign in_bnd    = s_tdata[S_BND_LSB +: BND_W];
    assign in_idx    = s_tdata[S_IDX_LSB +: IDX_W];
    assign in_col    = s_tdata[S_COL_LSB +: COL_W];
    assign in_idx_ok = WIDTH_W'(in_idx) < ENTRIES_W;
    assign in_col_ok = WIDTH_W'(in_col) < COLUMNS_W;
    assign in_slot   = POS_W'(POS_W'(in_bnd) * EPB_P) + POS_W'(in_idx);
    assign in_col_w  = WIDTH_W'(in_col);

    assign ds_eff    = (ds_reg == '0) ? DS_W'(1) : ds_reg;
    assign width_eff = (WIDTH_W'(rowc_reg) > COLUMNS_W) ? COLUMNS_W : WIDTH_W'(rowc_reg);

    assign tbl_we = s_xfer && (in_func == FUNC_LOAD_ENTRY) && in_idx_ok;
    assign row_we = s_xfer && (in_func == FUNC_LOAD_PIXEL) && in_col_ok;

    tpbc_ram #(
        .WIDTH (NUM_PLANES * WIRE_W),
        .DEPTH (4 * ENTRIES_PER_BOUNDARY)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (in_slot[TAW-1:0]),
        .wdata (s_tdata[S_WIRE_LSB +: NUM_PLANES*WIRE_W]),
        .raddr (slot_reg),
        .rdata (tbl_rdata)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        tpbc_ram #(
            .WIDTH (CHG_W),
            .DEPTH (COLUMNS)
        ) u_row (
            .aclk  (aclk),
            .we    (row_we),
            .waddr (in_col_w[AW-1:0]),
            .wdata (s_tdata[S_CHG_LSB + p*CHG_W +: CHG_W]),
            .raddr (row_raddr[p]),
            .rdata (row_rdata[p])
        );

        always_comb begin
            r_eff[p]   = (RAD_W'(rad_reg[p]) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                                  : RAD_W'(rad_reg[p]);
            cmr[p]     = POS_W'(q_reg[p]) - POS_W'(r_eff[p]);
            pos[p]     = cmr[p] + POS_W'(n_reg);
            // negative columns wrap to the top bit; reject them and those past the row
            pos_ok[p]  = !pos[p][POS_W-1] && (pos[p][WIDTH_W-1:0] < width_eff);
            row_raddr[p] = pos[p][AW-1:0];
            // one restoring division step
            shifted[p] = {rem_reg[p], q_reg[p][WIRE_W-1]};
            diff[p]    = shifted[p] - {1'b0, ds_eff};
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign matched  = inrange_reg && (|mask_reg[0]) && (|mask_reg[1]) && (|mask_reg[2]);

    // configuration writes
    always_comb begin
        thr_next  = thr_reg;
        rad_next  = rad_reg;
        ds_next   = ds_reg;
        rowc_next = rowc_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_THR_U:   thr_next[0] = cfg_data;
                REG_THR_V:   thr_next[1] = cfg_data;
                REG_THR_Y:   thr_next[2] = cfg_data;
                REG_RAD_U:   rad_next[0] = cfg_data[3:0];
                REG_RAD_V:   rad_next[1] = cfg_data[3:0];
                REG_RAD_Y:   rad_next[2] = cfg_data[3:0];
                REG_DS:      ds_next     = cfg_data[DS_W-1:0];
                REG_ROWCOLS: rowc_next   = cfg_data[ROWC_W-1:0];
                default:     ds_next     = ds_reg;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        bnd_next      = bnd_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        inrange_next  = inrange_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        mask_next     = mask_reg;
        pv_next       = 1'b0;
        pn_next       = n_reg;
        pok_next      = pos_ok;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        // compare stage of the scan, in the cycle after the row reads
        if (pv_reg) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (pok_reg[p] && ({1'b0, pn_reg} <= {r_eff[p], 1'b0})
                    && ($signed(row_rdata[p]) > thr_reg[p])) begin
                    mask_next[p][pn_reg] = 1'b1;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (in_func == FUNC_EVAL)) begin
                    bnd_next     = in_bnd;
                    idx_next     = in_idx;
                    slot_next    = in_slot[TAW-1:0];
                    inrange_next = in_idx_ok;
                    state_next   = in_idx_ok ? ST_TRD : ST_FIN;
                end
            end
            ST_TRD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    q_next[p]    = tbl_rdata[p*WIRE_W +: WIRE_W];
                    rem_next[p]  = '0;
                    mask_next[p] = '0;
                end
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    if (!diff[p][DS_W]) begin
                        rem_next[p] = diff[p][DS_W-1:0];
                        q_next[p]   = {q_reg[p][WIRE_W-2:0], 1'b1};
                    end else begin
                        rem_next[p] = shifted[p][DS_W-1:0];
                        q_next[p]   = {q_reg[p][WIRE_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    n_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pv_next = 1'b1;
                n_next  = n_reg + NIDX_W'(1);
                if (n_reg == NIDX_W'(SCAN_LAST)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = matched;
                    m_tdata_next  = {
                        matched ? mask_reg[2] : MASK_W'(0),
                        matched ? mask_reg[1] : MASK_W'(0),
                        matched ? mask_reg[0] : MASK_W'(0),
                        inrange_reg ? cmr[2][BASE_W-1:0] : BASE_W'(0),
                        inrange_reg ? cmr[1][BASE_W-1:0] : BASE_W'(0),
                        inrange_reg ? cmr[0][BASE_W-1:0] : BASE_W'(0),
                        idx_reg,
                        bnd_reg
                    };
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            pv_reg       <= 1'b0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                thr_reg[p] <= CHG_W'(10);
                rad_reg[p] <= 4'd1;
            end
            ds_reg       <= DS_W'(1);
            rowc_reg     <= ROWC_W'(1024);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            pv_reg       <= pv_next;
            thr_reg      <= thr_next;
            rad_reg      <= rad_next;
            ds_reg       <= ds_next;
            rowc_reg     <= rowc_next;
        end
    end

    always_ff @(posedge aclk) begin
        bnd_reg     <= bnd_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        inrange_reg <= inrange_next;
        cnt_reg     <= cnt_next;
        n_reg       <= n_next;
        pn_reg      <= pn_next;
        pok_reg     <= pok_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        mask_reg    <= mask_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== src/tpbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tpbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb_three_plane_boundary_coincidence.sv =====
// Testbench for the three-plane boundary coincidence block: directed table plus random phases.
module tb_three_plane_boundary_coincidence;
    import tpbc_pkg::*;

    localparam int ROW_COLS     = 1024;
    localparam int ENTRIES      = 1024;
    localparam int MAX_RAD      = 8;
    localparam int PHASE_ITEMS  = 117;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_LIMIT  = 20000;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int M_BND_LSB  = 0;
    localparam int M_IDX_LSB  = 2;
    localparam int M_BASE_LSB = 12;
    localparam int M_MASK_LSB = 45;

    typedef struct packed {
        logic [FUNC_W-1:0]                 func;
        logic [BND_W-1:0]                  bnd;
        logic [IDX_W-1:0]                  idx;
        logic [NUM_PLANES-1:0][WIRE_W-1:0] wires;
        logic [COL_W-1:0]                  col;
        logic [NUM_PLANES-1:0][CHG_W-1:0]  chg;
    } stream_item_t;

    typedef struct packed {
        logic                              matched;
        logic [BND_W-1:0]                  bnd;
        logic [IDX_W-1:0]                  idx;
        logic [NUM_PLANES-1:0][BASE_W-1:0] base;
        logic [NUM_PLANES-1:0][MASK_W-1:0] mask;
    } coincidence_t;

    typedef struct packed {
        stream_item_t item;
        logic         typed;
        coincidence_t res;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    three_plane_boundary_coincidence #(
        .COLUMNS              (ROW_COLS),
        .ENTRIES_PER_BOUNDARY (ENTRIES),
        .MAX_RADIUS           (MAX_RAD)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block state and registers
    logic signed [CHG_W-1:0]           row_charge [NUM_PLANES][ROW_COLS];
    bit                                col_written [ROW_COLS];
    logic [NUM_PLANES-1:0][WIRE_W-1:0] entry_wires [4*ENTRIES];
    bit                                entry_written [4*ENTRIES];
    int                                written_slots [$];
    logic signed [CHG_W-1:0]           thr_q [NUM_PLANES];
    logic [3:0]                        rad_q [NUM_PLANES];
    logic [4:0]                        ds_q;
    logic [10:0]                       rowc_q;

    coincidence_t  pending_coincidences [$];
    directed_row_t directed_rows [$];
    string         plane_tag [NUM_PLANES] = '{"u", "v", "y"};

    bit quiet;
    bit hold_req;
    int mismatch_count;
    int results_checked;
    int matched_seen;
    int items_accepted;
    int evals_sent;
    int settings_count;
    int cycle_count;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < 50)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic int eff_ds();
        return (ds_q == 0) ? 1 : int'(ds_q);
    endfunction

    function automatic int eff_width();
        return (rowc_q > ROW_COLS) ? ROW_COLS : int'(rowc_q);
    endfunction

    function automatic int eff_radius(int p);
        return (rad_q[p] > MAX_RAD) ? MAX_RAD : int'(rad_q[p]);
    endfunction

    function automatic int window_centre(int slot, int p);
        return int'(entry_wires[slot][p]) / eff_ds();
    endfunction

    function automatic coincidence_t predict_coincidence(logic [BND_W-1:0] bnd,
                                                         logic [IDX_W-1:0] idx);
        coincidence_t     res;
        int               slot, width, centre, r, c;
        logic [MASK_W-1:0] hits;
        logic             all_planes;
        res = '0;
        res.bnd = bnd;
        res.idx = idx;
        slot = int'(bnd) * ENTRIES + int'(idx);
        width = eff_width();
        all_planes = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            centre = window_centre(slot, p);
            r = eff_radius(p);
            res.base[p] = BASE_W'(centre - r);   // wraps for large centres
            hits = '0;
            for (int n = -r; n <= r; n++) begin
                c = centre + n;
                if (c >= 0 && c < width && row_charge[p][c] > thr_q[p])
                    hits[n + r] = 1'b1;
            end
            if (hits == '0)
                all_planes = 1'b0;
            res.mask[p] = hits;
        end
        res.matched = all_planes;
        if (!all_planes)
            res.mask = '0;
        return res;
    endfunction

    function automatic logic [CHG_W-1:0] rand_charge(int p);
        int                      v, t;
        logic signed [CHG_W-1:0] s;
        t = thr_q[p];
        case ($urandom_range(0, 3))
            0: begin
                s = CHG_W'($urandom);
                v = s;
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = t;
                    default: v = t + 1;
                endcase
            end
            default: v = t + int'($urandom_range(0, 60)) - 30;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return CHG_W'(v);
    endfunction

    // wire that lands near or inside the valid part of the row for the current setting
    function automatic logic [WIRE_W-1:0] target_wire();
        int dsv, width, centre;
        dsv = eff_ds();
        width = eff_width();
        if (width == 0 || $urandom_range(0, 9) == 0)
            return WIRE_W'($urandom);
        centre = $urandom_range(0, width + 1);
        return WIRE_W'(centre * dsv + int'($urandom_range(0, dsv - 1)));
    endfunction

    function automatic stream_item_t noise_item();
        stream_item_t it;
        it.func = FUNC_UNUSED;
        it.bnd = BND_W'($urandom);
        it.idx = IDX_W'($urandom);
        it.col = COL_W'($urandom);
        for (int p = 0; p < NUM_PLANES; p++) begin
            it.wires[p] = WIRE_W'($urandom);
            it.chg[p] = CHG_W'($urandom);
        end
        return it;
    endfunction

    function automatic stream_item_t mk_entry(logic [BND_W-1:0] bnd, logic [IDX_W-1:0] idx,
                                              logic [WIRE_W-1:0] wu, logic [WIRE_W-1:0] wv,
                                              logic [WIRE_W-1:0] wy);
        stream_item_t it;
        it = noise_item();
        it.func = FUNC_LOAD_ENTRY;
        it.bnd = bnd;
        it.idx = idx;
        it.wires = {wy, wv, wu};
        return it;
    endfunction

    function automatic stream_item_t mk_pixel(logic [COL_W-1:0] col, logic [CHG_W-1:0] cu,
                                              logic [CHG_W-1:0] cv, logic [CHG_W-1:0] cy);
        stream_item_t it;
        it = noise_item();
        it.func = FUNC_LOAD_PIXEL;
        it.col = col;
        it.chg = {cy, cv, cu};
        return it;
    endfunction

    function automatic stream_item_t mk_eval(logic [BND_W-1:0] bnd, logic [IDX_W-1:0] idx);
        stream_item_t it;
        it = noise_item();
        it.func = FUNC_EVAL;
        it.bnd = bnd;
        it.idx = idx;
        return it;
    endfunction

    function automatic coincidence_t mk_result(logic m, logic [BND_W-1:0] bnd,
                                               logic [IDX_W-1:0] idx, int bu, int bv, int by,
                                               int ku, int kv, int ky);
        coincidence_t res;
        res.matched = m;
        res.bnd = bnd;
        res.idx = idx;
        res.base = {BASE_W'(by), BASE_W'(bv), BASE_W'(bu)};
        res.mask = {MASK_W'(ky), MASK_W'(kv), MASK_W'(ku)};
        return res;
    endfunction

    function automatic directed_row_t dir_row(stream_item_t it, logic typed, coincidence_t res);
        directed_row_t row;
        row.item = it;
        row.typed = typed;
        row.res = res;
        return row;
    endfunction

    task automatic append_row(directed_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_item(stream_item_t it, bit use_typed, coincidence_t typed_res);
        int                   slot;
        logic [S_TDATA_W-1:0] d;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        d = '0;
        d[S_BND_LSB +: BND_W] = it.bnd;
        d[S_IDX_LSB +: IDX_W] = it.idx;
        d[S_COL_LSB +: COL_W] = it.col;
        for (int p = 0; p < NUM_PLANES; p++) begin
            d[S_WIRE_LSB + p*WIRE_W +: WIRE_W] = it.wires[p];
            d[S_CHG_LSB + p*CHG_W +: CHG_W] = it.chg[p];
        end
        s_tdata <= d;
        s_tuser <= it.func;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        slot = int'(it.bnd) * ENTRIES + int'(it.idx);
        case (it.func)
            FUNC_LOAD_ENTRY: begin
                entry_wires[slot] = it.wires;
                if (!entry_written[slot])
                    written_slots.insert(written_slots.size(), slot);
                entry_written[slot] = 1'b1;
            end
            FUNC_LOAD_PIXEL: begin
                for (int p = 0; p < NUM_PLANES; p++)
                    row_charge[p][it.col] = it.chg[p];
                col_written[it.col] = 1'b1;
            end
            FUNC_EVAL: begin
                pending_coincidences.insert(pending_coincidences.size(),
                                            use_typed ? typed_res
                                                      : predict_coincidence(it.bnd, it.idx));
                evals_sent++;
            end
            default: ;
        endcase
        if (it.func != FUNC_UNUSED)
            items_accepted++;
    endtask

    // load every column the entry will look at that was never written, and with refresh some written ones again
    task automatic cover_window(int slot, bit refresh);
        int width, centre, r;
        width = eff_width();
        for (int p = 0; p < NUM_PLANES; p++) begin
            centre = window_centre(slot, p);
            r = eff_radius(p);
            for (int c = centre - r; c <= centre + r; c++) begin
                if (c >= 0 && c < width &&
                    (!col_written[c] || (refresh && $urandom_range(0, 2) == 0)))
                    send_item(mk_pixel(COL_W'(c), rand_charge(0), rand_charge(1),
                                       rand_charge(2)), 1'b0, '0);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_coincidences.size() != 0)
            @(posedge aclk);
        // a load may still be in flight after the last result
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int value);
        cfg_index <= index;
        cfg_data <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_THR_U:   thr_q[0] = CHG_W'(value);
            REG_THR_V:   thr_q[1] = CHG_W'(value);
            REG_THR_Y:   thr_q[2] = CHG_W'(value);
            REG_RAD_U:   rad_q[0] = 4'(value);
            REG_RAD_V:   rad_q[1] = 4'(value);
            REG_RAD_Y:   rad_q[2] = 4'(value);
            REG_DS:      ds_q = 5'(value);
            REG_ROWCOLS: rowc_q = 11'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(int tu, int tv, int ty, int ru, int rv, int ry, int ds, int rc);
        wait_drained();
        write_reg(REG_THR_U, tu);
        write_reg(REG_THR_V, tv);
        write_reg(REG_THR_Y, ty);
        write_reg(REG_RAD_U, ru);
        write_reg(REG_RAD_V, rv);
        write_reg(REG_RAD_Y, ry);
        write_reg(REG_DS, ds);
        write_reg(REG_ROWCOLS, rc);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic run_phase(int quota, bit pause_midway);
        int               start, pick, slot;
        bit               paused;
        logic [BND_W-1:0] bnd;
        logic [IDX_W-1:0] idx;
        start = items_accepted;
        paused = 1'b0;
        while (items_accepted - start < quota) begin
            if (pause_midway && !paused && items_accepted - start > quota / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55 || written_slots.size() == 0) begin
                // load an entry, make its neighbourhood valid, evaluate it
                bnd = BND_W'($urandom);
                idx = IDX_W'($urandom);
                slot = int'(bnd) * ENTRIES + int'(idx);
                send_item(mk_entry(bnd, idx, target_wire(), target_wire(), target_wire()),
                          1'b0, '0);
                cover_window(slot, 1'b1);
                send_item(mk_eval(bnd, idx), 1'b0, '0);
            end else if (pick < 80) begin
                slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
                cover_window(slot, 1'b0);
                send_item(mk_eval(BND_W'(slot / ENTRIES), IDX_W'(slot % ENTRIES)), 1'b0, '0);
            end else if (pick < 95) begin
                if ($urandom_range(0, 1) == 0)
                    send_item(mk_entry(BND_W'($urandom), IDX_W'($urandom), WIRE_W'($urandom),
                                       WIRE_W'($urandom), WIRE_W'($urandom)),
                              1'b0, '0);
                else
                    send_item(mk_pixel(COL_W'($urandom), rand_charge(0), rand_charge(1),
                                       rand_charge(2)), 1'b0, '0);
            end else begin
                send_item(noise_item(), 1'b0, '0);
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                for (int k = 0; k < LONG_HOLD; k++)
                    @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        coincidence_t want;
        coincidence_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.matched = m_tuser[0];
            got.bnd = m_tdata[M_BND_LSB +: BND_W];
            got.idx = m_tdata[M_IDX_LSB +: IDX_W];
            for (int p = 0; p < NUM_PLANES; p++) begin
                got.base[p] = m_tdata[M_BASE_LSB + p*BASE_W +: BASE_W];
                got.mask[p] = m_tdata[M_MASK_LSB + p*MASK_W +: MASK_W];
            end
            if (pending_coincidences.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, out_index %0d",
                                          got.idx));
            end else begin
                want = pending_coincidences.pop_front();
                results_checked++;
                if (want.matched)
                    matched_seen++;
                check_field("matched", got.matched, want.matched);
                check_field("out_boundary", got.bnd, want.bnd);
                check_field("out_index", got.idx, want.idx);
                for (int p = 0; p < NUM_PLANES; p++) begin
                    check_field({"base_col_", plane_tag[p]}, got.base[p], want.base[p]);
                    check_field({"mask_", plane_tag[p]}, got.mask[p], want.mask[p]);
                end
            end
        end
    end

    initial begin : stimulus
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        aresetn <= 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            thr_q[p] = 16'sd10;
            rad_q[p] = 4'd1;
        end
        ds_q = 5'd1;
        rowc_q = 11'd1024;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, run at the reset settings (threshold 10, radius 1, full row)
        append_row(dir_row(mk_entry(0, 0, 0, 0, 0), 0, '0));
        append_row(dir_row(mk_pixel(0, 16'd11, 16'd11, 16'd11), 0, '0));
        append_row(dir_row(mk_pixel(1, 16'd10, 16'd10, 16'd10), 0, '0));
        append_row(dir_row(mk_eval(0, 0), 1,
            mk_result(1, 0, 0, 'h7FF, 'h7FF, 'h7FF, 2, 2, 2)));
        // centre far past the row: nothing tested, base wraps
        append_row(dir_row(mk_entry(3, 1023, 'hFFF, 'hFFF, 'hFFF), 0, '0));
        append_row(dir_row(mk_eval(3, 1023), 1,
            mk_result(0, 3, 1023, 'h7FE, 'h7FE, 'h7FE, 0, 0, 0)));
        // charge extremes at the right edge of the row
        append_row(dir_row(mk_pixel(1023, 16'h7FFF, 16'h8000, 16'h0000), 0, '0));
        append_row(dir_row(mk_pixel(1022, 16'hFFFF, 16'h7FFF, 16'd11), 0, '0));
        append_row(dir_row(mk_entry(1, 512, 1023, 1023, 1023), 0, '0));
        append_row(dir_row(mk_eval(1, 512), 1,
            mk_result(1, 1, 512, 1022, 1022, 1022, 2, 1, 1)));
        append_row(dir_row(noise_item(), 0, '0));
        append_row(dir_row(mk_entry(2, 'h2AA, 'hAAA, 'h555, 1), 0, '0));
        append_row(dir_row(mk_pixel(2, 16'h5555, 16'hAAAA, 16'h7FFF), 0, '0));
        // plane y hits but u and v fall outside the row
        append_row(dir_row(mk_eval(2, 'h2AA), 1,
            mk_result(0, 2, 'h2AA, 681, 1364, 0, 0, 0, 0)));
        append_row(dir_row(mk_eval(0, 0), 0, '0));
        append_row(dir_row(mk_eval(1, 512), 0, '0));
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

        run_phase(PHASE_ITEMS, 1'b0);
        set_config(0, 0, 0, 2, 3, 4, 4, 512);
        run_phase(PHASE_ITEMS, 1'b0);
        // lowest thresholds, widest window: results back up while the sink holds off
        set_config(-32768, -32768, -32768, 8, 8, 8, 16, 1024);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        set_config(32767, 32767, 32767, 0, 0, 0, 1, 1);
        run_phase(PHASE_ITEMS, 1'b1);
        // clamped radius, zero downsample, oversized row width
        set_config(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                   int'($urandom_range(0, 200)) - 100, 15, 9, 12, 0, 2047);
        run_phase(PHASE_ITEMS, 1'b0);
        set_config(10, -5, 20, 8, 0, 5, 31, 0);
        run_phase(PHASE_ITEMS, 1'b0);
        set_config(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                   int'($urandom_range(0, 400)) - 200, $urandom_range(0, 8),
                   $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 16),
                   $urandom_range(1, 1024));
        run_phase(PHASE_ITEMS, 1'b0);
        set_config(int'($urandom_range(0, 60)) - 30, int'($urandom_range(0, 60)) - 30,
                   int'($urandom_range(0, 60)) - 30, $urandom_range(1, 8),
                   $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4),
                   $urandom_range(64, 1024));
        quiet = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);

        s_tvalid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_coincidences.size() != 0; k++)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (pending_coincidences.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_coincidences.size()));

        $display("covered %0d input transfers, %0d evaluations (%0d matching) under %0d settings",
                 items_accepted, evals_sent, matched_seen, settings_count + 1);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
